// ===== hdl/apu_pkg.sv =====
// Package for the Adam parameter update engine: register reset values,
// register indexes, datapath widths and the configuration struct.
// No dependencies.
package apu_pkg;

  localparam int unsigned MAX_PARAMS_DEF = 32;

  // Register reset values
  localparam logic [31:0] LR_RST  = 32'd429497;
  localparam logic [15:0] B1_RST  = 16'd58982;
  localparam logic [15:0] B2_RST  = 16'd64881;
  localparam logic [31:0] EPS_RST = 32'd43;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS = 8'd3;

  // Item mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Memory word: parameter, first moment, second moment
  localparam int unsigned MEM_W = 128;

  // Divider widths and step cap
  localparam int unsigned NUM_W  = 80;
  localparam int unsigned DEN_W  = 64;
  localparam int unsigned STEP_W = 41;
  localparam logic [STEP_W-1:0] STEP_CAP = 41'h100_0000_0000;

  typedef struct packed {
    logic [31:0] lr;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [31:0] eps;
    logic [31:0] p1;
    logic [31:0] p2;
  } cfg_t;

endpackage

// ===== hdl/apu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apu_ram #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/apu_sqrt.sv =====
// Iterative 64-bit integer square root, one result bit per cycle.
// No dependencies.
module apu_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, res_q, bit_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [63:0] trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[31:0];

  // Sequence the 32 steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring root step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (run_q) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ===== hdl/apu_div.sv =====
// Iterative restoring divider, 80-bit dividend by 64-bit divisor, one bit per cycle.
// Depends on apu_pkg.
module apu_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [apu_pkg::NUM_W-1:0] num_i,
  input  logic [apu_pkg::DEN_W-1:0] den_i,
  output logic                     done_o,
  output logic [apu_pkg::NUM_W-1:0] quo_o
);
  import apu_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] n_q;
  logic [DEN_W-1:0] d_q, r_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DEN_W:0]   r2;
  logic             ge;

  assign r2     = {r_q, n_q[NUM_W-1]};
  assign ge     = r2 >= {1'b0, d_q};
  assign done_o = done_q;
  assign quo_o  = n_q;

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in a dividend bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
    end else if (run_q) begin
      r_q <= ge ? DEN_W'(r2 - {1'b0, d_q}) : r2[DEN_W-1:0];
      n_q <= {n_q[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/apu_ctrl.sv =====
// Sequencer and datapath of the Adam update: read-modify-write of the
// state memory, moment updates, bias correction through shared root and divider.
// Depends on apu_pkg, apu_sqrt, apu_div.
module apu_ctrl #(
  parameter int unsigned MAX_PARAMS = apu_pkg::MAX_PARAMS_DEF,
  localparam int unsigned AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       mode_i,
  input  logic [4:0]                 param_index_i,
  input  logic signed [31:0]         value_i,
  input  logic                       last_of_iteration_i,
  output logic                       busy_o,
  input  apu_pkg::cfg_t              cfg_i,
  output logic                       adv_o,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output logic [apu_pkg::MEM_W-1:0]  wdata_o,
  output logic [AW-1:0]              raddr_o,
  input  logic [apu_pkg::MEM_W-1:0]  rdata_i,
  output logic                       res_valid_o,
  output logic [4:0]                 result_index_o,
  output logic signed [31:0]         new_value_o,
  output logic                       saturated_o
);
  import apu_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_MA, S_MB, S_MC,
    S_SQV, S_SQV_W, S_SQD, S_SQD_W,
    S_DIV1, S_DIV1_W, S_DIV2, S_DIV2_W,
    S_PR1, S_PR2, S_DIV3, S_DIV3_W, S_FIN
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;

  // Payload registers
  logic [4:0]          idx_q;
  logic                last_q;
  logic signed [31:0]  g_q, p_q, m_q;
  logic [63:0]         vo_q, v_q, vt_q, g2_q;
  logic signed [63:0]  pa_q, s_q;
  logic [31:0]         sqv_q;
  logic [32:0]         qd_q;
  logic [47:0]         mhat_q;
  logic [39:0]         root_q;
  logic [63:0]         pl_q;
  logic [NUM_W-1:0]    num_q;

  logic                accept, in_rng;
  logic [16:0]         cb1, cb2;
  logic [31:0]         gmag, mmag;
  logic [32:0]         d1, d2;
  logic signed [63:0]  sadj;
  logic [DEN_W-1:0]    den3;
  logic [47:0]         ph;
  logic [STEP_W-1:0]   step;
  logic signed [42:0]  newp;
  logic signed [31:0]  newv;
  logic                sat;

  logic                sq_start, sq_done;
  logic [63:0]         sq_x;
  logic [31:0]         sq_root;
  logic                dv_start, dv_done;
  logic [NUM_W-1:0]    dv_num, dv_quo;
  logic [DEN_W-1:0]    dv_den;

  function automatic logic [63:0] mul_q16(input logic [63:0] x, input logic [16:0] c);
    logic [63:0] hi;
    logic [32:0] lo;
    hi = x[63:16] * c;
    lo = x[15:0] * c;
    return hi + 64'(lo[32:16]);
  endfunction

  assign accept = start_i && (state_q == S_IDLE);
  assign in_rng = {27'b0, param_index_i} < MAX_PARAMS;
  assign busy_o = state_q != S_IDLE;

  assign cb1  = 17'h10000 - {1'b0, cfg_i.b1};
  assign cb2  = 17'h10000 - {1'b0, cfg_i.b2};
  assign gmag = g_q[31] ? (~g_q + 32'd1) : g_q;
  assign mmag = m_q[31] ? (~m_q + 32'd1) : m_q;
  assign d1   = 33'h1_0000_0000 - {1'b0, cfg_i.p1};
  assign d2   = 33'h1_0000_0000 - {1'b0, cfg_i.p2};
  assign sadj = s_q + (s_q[63] ? 64'sd65535 : 64'sd0);
  assign den3 = {8'b0, root_q, 16'b0} + {32'b0, cfg_i.eps};
  assign ph   = cfg_i.lr * mhat_q[47:32];

  // Final step: cap, sign of the moment, saturate to Q16.16
  always_comb begin
    if (den3 == '0) begin
      step = '0;
    end else if (dv_quo >= NUM_W'(STEP_CAP)) begin
      step = STEP_CAP;
    end else begin
      step = dv_quo[STEP_W-1:0];
    end
    newp = m_q[31] ? (43'(p_q) + 43'(step)) : (43'(p_q) - 43'(step));
    sat  = (newp > 43'sh7FFF_FFFF) || (newp < -43'sh8000_0000);
    // clamp to the rail on the side of overflow
    if (sat) begin
      newv = newp[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      newv = newp[31:0];
    end
  end

  // Shared unit operands by state
  assign sq_start = (state_q == S_SQV) || (state_q == S_SQD);
  assign sq_x     = (state_q == S_SQV) ? v_q : {d2[31:0], 32'b0};
  assign dv_start = (state_q == S_DIV1) || (state_q == S_DIV2) || (state_q == S_DIV3);
  always_comb begin
    unique case (state_q)
      S_DIV1: begin
        dv_num = {16'b0, mmag, 32'b0};
        dv_den = {31'b0, d1};
      end
      S_DIV2: begin
        dv_num = {16'b0, sqv_q, 32'b0};
        dv_den = {31'b0, qd_q};
      end
      default: begin
        dv_num = num_q;
        dv_den = den3;
      end
    endcase
  end

  apu_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .x_i(sq_x), .done_o(sq_done), .root_o(sq_root)
  );

  apu_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  // Memory ports
  always_comb begin
    raddr_o = (state_q == S_IDLE) ? AW'(param_index_i) : AW'(idx_q);
    we_o    = 1'b0;
    waddr_o = AW'(idx_q);
    wdata_o = {p_q, m_q, v_q};
    adv_o   = 1'b0;
    priority case (state_q)
      S_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = '0;
      end
      S_IDLE: begin
        waddr_o = AW'(param_index_i);
        wdata_o = {value_i, 32'b0, 64'b0};
        we_o    = accept && (mode_i == MODE_LOAD) && in_rng;
        adv_o   = accept && (mode_i == MODE_UPDATE) && !in_rng && last_of_iteration_i;
      end
      S_FIN: begin
        we_o    = 1'b1;
        wdata_o = {newv, m_q, v_q};
        adv_o   = last_q;
      end
      default: ;
    endcase
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      res_valid_o    <= 1'b0;
      result_index_o <= '0;
      new_value_o    <= '0;
      saturated_o    <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAX_PARAMS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (mode_i == MODE_UPDATE && in_rng) begin
              state_q <= S_RD;
            end else begin
              res_valid_o    <= 1'b1;
              result_index_o <= param_index_i;
              new_value_o    <= (mode_i == MODE_LOAD && in_rng) ? value_i : '0;
              saturated_o    <= 1'b0;
            end
          end
        end
        S_RD:     state_q <= S_MA;
        S_MA:     state_q <= S_MB;
        S_MB:     state_q <= S_MC;
        S_MC:     state_q <= S_SQV;
        S_SQV:    state_q <= S_SQV_W;
        S_SQV_W:  if (sq_done) state_q <= d2[32] ? S_DIV1 : S_SQD;
        S_SQD:    state_q <= S_SQD_W;
        S_SQD_W:  if (sq_done) state_q <= S_DIV1;
        S_DIV1:   state_q <= S_DIV1_W;
        S_DIV1_W: if (dv_done) state_q <= S_DIV2;
        S_DIV2:   state_q <= S_DIV2_W;
        S_DIV2_W: if (dv_done) state_q <= S_PR1;
        S_PR1:    state_q <= S_PR2;
        S_PR2:    state_q <= (den3 == '0) ? S_FIN : S_DIV3;
        S_DIV3:   state_q <= S_DIV3_W;
        S_DIV3_W: if (dv_done) state_q <= S_FIN;
        S_FIN: begin
          state_q        <= S_IDLE;
          res_valid_o    <= 1'b1;
          result_index_o <= idx_q;
          new_value_o    <= newv;
          saturated_o    <= sat;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        idx_q  <= param_index_i;
        last_q <= last_of_iteration_i;
        g_q    <= value_i;
      end
      S_RD: begin
        // read data arrives this cycle
        p_q  <= rdata_i[127:96];
        vo_q <= rdata_i[63:0];
        pa_q <= 64'($signed({1'b0, cfg_i.b1})) * 64'($signed(rdata_i[95:64]));
      end
      S_MA: begin
        s_q  <= pa_q + 64'($signed({1'b0, cb1})) * 64'(g_q);
        g2_q <= gmag * gmag;
      end
      S_MB: begin
        m_q  <= 32'(sadj >>> 16);
        vt_q <= mul_q16(vo_q, {1'b0, cfg_i.b2});
      end
      S_MC: v_q <= vt_q + mul_q16(g2_q, cb2);
      S_SQV_W: begin
        sqv_q <= sq_root;
        qd_q  <= 33'h1_0000_0000;
      end
      S_SQD_W:  qd_q <= {1'b0, sq_root};
      S_DIV1_W: mhat_q <= dv_quo[47:0];
      S_DIV2_W: root_q <= dv_quo[39:0];
      S_PR1:    pl_q <= cfg_i.lr * mhat_q[31:0];
      S_PR2:    num_q <= {16'b0, pl_q} + {ph, 32'b0};
      default: ;
    endcase
  end

endmodule

// ===== hdl/adam_parameter_update_top.sv =====
// Adam parameter update engine: a load item, or any item whose index is out of range, is
// accepted and its result strobes on the next cycle; the next item can follow at once.
// An update item runs two 32-step square roots and three 80-step divisions before its
// result (the second root is skipped when the beta2 power is zero, the last division on a
// zero denominator). One item at a time; busy stays high until the result strobe.
// After reset a clearing pass zeroes the state memory, busy high.
module adam_parameter_update_top #(
  parameter int unsigned MAX_PARAMS = apu_pkg::MAX_PARAMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode_i,
  input  logic [4:0]                      param_index_i,
  input  logic signed [31:0]              value_i,
  input  logic                            last_of_iteration_i,
  output logic                            res_valid_o,
  output logic [4:0]                      result_index_o,
  output logic signed [31:0]              new_value_o,
  output logic                            saturated_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [apu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import apu_pkg::*;

  localparam int unsigned AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  cfg_t          cfg_q;
  logic          adv, we, cfg_wr;
  logic [AW-1:0] waddr, raddr;
  logic [MEM_W-1:0] wdata, rdata;
  logic [47:0]   p1m, p2m;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign p1m         = cfg_q.p1 * cfg_q.b1;
  assign p2m         = cfg_q.p2 * cfg_q.b2;

  // Configuration registers and decay powers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr  <= LR_RST;
      cfg_q.b1  <= B1_RST;
      cfg_q.b2  <= B2_RST;
      cfg_q.eps <= EPS_RST;
      cfg_q.p1  <= {B1_RST, 16'b0};
      cfg_q.p2  <= {B2_RST, 16'b0};
    end else if (cfg_wr) begin
      priority case (cfg_index_i)
        CFG_LR:  cfg_q.lr <= cfg_data_i;
        CFG_B1: begin
          cfg_q.b1 <= cfg_data_i[15:0];
          cfg_q.p1 <= {cfg_data_i[15:0], 16'b0};
        end
        CFG_B2: begin
          cfg_q.b2 <= cfg_data_i[15:0];
          cfg_q.p2 <= {cfg_data_i[15:0], 16'b0};
        end
        CFG_EPS: cfg_q.eps <= cfg_data_i;
        default: ;
      endcase
    end else if (adv) begin
      // advance bias-correction powers at the end of an iteration
      cfg_q.p1 <= p1m[47:16];
      cfg_q.p2 <= p2m[47:16];
    end
  end

  apu_ram #(.W(MEM_W), .DEPTH(MAX_PARAMS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  apu_ctrl #(.MAX_PARAMS(MAX_PARAMS)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .mode_i, .param_index_i, .value_i, .last_of_iteration_i,
    .busy_o(busy), .cfg_i(cfg_q), .adv_o(adv),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata),
    .res_valid_o, .result_index_o, .new_value_o, .saturated_o
  );

endmodule

// ===== hdl/apu_checker.sv =====
// Port-level assertions for the Adam parameter update engine, bound to the top level.
// Depends on apu_pkg and adam_parameter_update_top.
module apu_checker #(
  parameter int unsigned MAX_PARAMS = apu_pkg::MAX_PARAMS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          mode_i,
  input logic [4:0]                    param_index_i,
  input logic signed [31:0]            value_i,
  input logic                          res_valid_o,
  input logic [4:0]                    result_index_o,
  input logic signed [31:0]            new_value_o,
  input logic                          saturated_o
);
  import apu_pkg::*;

  logic acc, rng;
  assign acc = start && !busy;
  assign rng = {27'b0, param_index_i} < MAX_PARAMS;

  // Load or out-of-range transaction answers on the next cycle with its index
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (mode_i == MODE_LOAD || !rng) |=>
      res_valid_o && result_index_o == $past(param_index_i))
    else $error("missing immediate result");

  // In-range load echoes the stored value without saturation
  a_load_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mode_i == MODE_LOAD && rng |=> new_value_o == $past(value_i) && !saturated_o)
    else $error("load result mismatch");

  // Saturated result sits at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && saturated_o |->
      new_value_o == 32'sh7FFF_FFFF || new_value_o == -32'sh8000_0000)
    else $error("saturated result off rail");

  // A result after an idle cycle follows a transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !$past(busy) |-> $past(start))
    else $error("result without transaction");

endmodule

bind adam_parameter_update_top apu_checker #(.MAX_PARAMS(MAX_PARAMS)) u_apu_checker (.*);

// ===== bench/adam_parameter_update_top_tb.sv =====
// Self-checking bench for the Adam parameter update engine.
// Uses apu_pkg and adam_parameter_update_top; a built-in predictor checks every result.
`timescale 1ns / 100ps

module adam_parameter_update_top_tb;
  import apu_pkg::*;

  localparam int unsigned NUM_PARAMS  = MAX_PARAMS_DEF;
  localparam longint      CYCLE_LIMIT = 3_000_000;
  localparam int          RAND_PER_PHASE = 210;
  localparam int          NUM_PHASES  = 5;

  typedef struct {
    logic              mode;
    logic [4:0]        idx;
    logic signed [31:0] value;
    logic              last;
  } grad_item_t;

  typedef struct {
    logic [4:0]         idx;
    logic signed [31:0] value;
    logic               sat;
  } param_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic mode_i = MODE_LOAD;
  logic [4:0] param_index_i = '0;
  logic signed [31:0] value_i = '0;
  logic last_of_iteration_i = 1'b0;
  logic res_valid_o;
  logic [4:0] result_index_o;
  logic signed [31:0] new_value_o;
  logic saturated_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_LR;
  logic [31:0] cfg_data_i = '0;

  adam_parameter_update_top u_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .param_index_i, .value_i,
    .last_of_iteration_i, .res_valid_o, .result_index_o, .new_value_o, .saturated_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the engine: registers, powers and per-index stores
  logic [31:0] alpha_r, eps_r, pow1_r, pow2_r;
  logic [15:0] beta1_r, beta2_r;
  logic signed [31:0] param_mem [NUM_PARAMS];
  logic signed [31:0] mom1_mem [NUM_PARAMS];
  logic [63:0] mom2_mem [NUM_PARAMS];

  grad_item_t pending_items_q[$];
  param_result_t expected_results_q[$];
  bit loaded[NUM_PARAMS];
  int errors = 0;
  int sender_idle_pct = 0;
  longint cycles = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (cand * cand <= x) r = cand;
    end
    return r;
  endfunction

  function automatic logic [63:0] frac_scale(input logic [63:0] x, input logic [63:0] c);
    return (x >> 16) * c + (((x & 64'hFFFF) * c) >> 16);
  endfunction

  // Reset the shadow registers and stores
  task automatic shadow_reset();
    alpha_r = LR_RST;
    beta1_r = B1_RST;
    beta2_r = B2_RST;
    eps_r   = EPS_RST;
    pow1_r  = {B1_RST, 16'd0};
    pow2_r  = {B2_RST, 16'd0};
    for (int i = 0; i < NUM_PARAMS; i++) begin
      param_mem[i] = '0;
      mom1_mem[i]  = '0;
      mom2_mem[i]  = '0;
    end
  endtask

  task automatic shadow_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_LR: alpha_r = data;
      CFG_B1: begin
        beta1_r = data[15:0];
        pow1_r  = {data[15:0], 16'd0};
      end
      CFG_B2: begin
        beta2_r = data[15:0];
        pow2_r  = {data[15:0], 16'd0};
      end
      CFG_EPS: eps_r = data;
      default: ;
    endcase
  endtask

  // Compute the result of one item and advance the shadow state
  function automatic param_result_t adam_step_predict(input grad_item_t it);
    param_result_t res;
    longint val, s, b1l, step_s, newp;
    logic signed [31:0] m;
    logic [63:0] gmag, v, d1, d2, mmag, mhat, q, root, den;
    logic [127:0] quot;
    val = it.value;
    res.idx = it.idx;
    res.sat = 1'b0;
    if (it.mode == MODE_LOAD) begin
      param_mem[it.idx] = it.value;
      mom1_mem[it.idx]  = '0;
      mom2_mem[it.idx]  = '0;
      res.value = it.value;
      return res;
    end
    b1l = beta1_r;
    s = b1l * longint'(mom1_mem[it.idx]) + (65536 - b1l) * val;
    m = 32'(s / 65536);
    gmag = (val < 0) ? -val : val;
    v = frac_scale(mom2_mem[it.idx], {48'd0, beta2_r})
      + frac_scale(gmag * gmag, 64'd65536 - beta2_r);
    d1 = 64'h1_0000_0000 - pow1_r;
    d2 = 64'h1_0000_0000 - pow2_r;
    mmag = (m < 0) ? -longint'(m) : longint'(m);
    mhat = (mmag << 32) / d1;
    q = (d2 == 64'h1_0000_0000) ? d2 : int_sqrt(d2 << 32);
    root = (int_sqrt(v) << 32) / q;
    den = (root << 16) + eps_r;
    mom1_mem[it.idx] = m;
    mom2_mem[it.idx] = v;
    step_s = 0;
    if (den != 0) begin
      quot = ({96'd0, alpha_r} * {64'd0, mhat}) / {64'd0, den};
      step_s = (quot >= (128'd1 << 40)) ? (longint'(1) << 40) : longint'(quot[63:0]);
    end
    newp = longint'(param_mem[it.idx]) - ((m < 0) ? -step_s : step_s);
    if (newp > 64'sd2147483647) begin
      newp = 64'sd2147483647;
      res.sat = 1'b1;
    end
    if (newp < -64'sd2147483648) begin
      newp = -64'sd2147483648;
      res.sat = 1'b1;
    end
    param_mem[it.idx] = 32'(newp);
    res.value = 32'(newp);
    // Advance the bias-correction powers at the iteration boundary
    if (it.last) begin
      pow1_r = 32'((64'(pow1_r) * beta1_r) >> 16);
      pow2_r = 32'((64'(pow2_r) * beta2_r) >> 16);
    end
    return res;
  endfunction

  // Drive items from the pending queue, predict on each accepted transaction
  always @(posedge clk_i) begin
    grad_item_t it;
    if (!(start && busy)) begin
      if (start) begin
        it = '{mode_i, param_index_i, value_i, last_of_iteration_i};
        expected_results_q.push_back(adam_step_predict(it));
      end
      if (pending_items_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        it = pending_items_q.pop_front();
        start <= 1'b1;
        mode_i <= it.mode;
        param_index_i <= it.idx;
        value_i <= it.value;
        last_of_iteration_i <= it.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    param_result_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (expected_results_q.size() == 0) begin
        $error("unexpected result: index %0d value %0d", result_index_o, new_value_o);
        errors++;
      end else begin
        exp_r = expected_results_q.pop_front();
        if (result_index_o !== exp_r.idx) begin
          $error("result_index: expected %0d actual %0d", exp_r.idx, result_index_o);
          errors++;
        end
        if (new_value_o !== exp_r.value) begin
          $error("new_value: expected %0d actual %0d", exp_r.value, new_value_o);
          errors++;
        end
        if (saturated_o !== exp_r.sat) begin
          $error("saturated: expected %0d actual %0d", exp_r.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_config(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_item(input logic mode, input logic [4:0] idx,
                           input logic [31:0] value, input logic last);
    grad_item_t it;
    it = '{mode, idx, value, last};
    if (mode == MODE_LOAD) loaded[idx] = 1'b1;
    pending_items_q.push_back(it);
  endtask

  // Hold until every item is sent and every result has arrived
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items_q.size() != 0 || expected_results_q.size() != 0 || start || busy);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(512)) - 256);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                  : 32'h8000_0000 + $urandom_range(255);
      default: return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  // Random items: mostly gradients on loaded indexes, some reloads
  task automatic push_random(input int n);
    logic [4:0] idx;
    for (int k = 0; k < n; k++) begin
      idx = $urandom_range(NUM_PARAMS - 1);
      if (!loaded[idx] || $urandom_range(99) < 25)
        push_item(MODE_LOAD, idx, pick_value(), $urandom_range(1));
      else
        push_item(MODE_UPDATE, idx, pick_value(), $urandom_range(99) < 20);
    end
  endtask

  initial begin
    shadow_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of values and indexes, iteration marks, reload
    push_item(MODE_LOAD, 5'd0, 32'h7FFF_FFFF, 1'b1);
    push_item(MODE_LOAD, 5'd31, 32'h8000_0000, 1'b0);
    push_item(MODE_LOAD, 5'd10, 32'h0001_0000, 1'b0);
    push_item(MODE_UPDATE, 5'd0, 32'h8000_0000, 1'b0);
    push_item(MODE_UPDATE, 5'd31, 32'h7FFF_FFFF, 1'b0);
    push_item(MODE_UPDATE, 5'd10, 32'h0000_0000, 1'b0);
    push_item(MODE_UPDATE, 5'd10, 32'hFFFF_FFFF, 1'b1);
    push_item(MODE_UPDATE, 5'd10, 32'h0000_0001, 1'b1);
    push_item(MODE_LOAD, 5'd10, 32'hFFFF_0000, 1'b1);
    push_item(MODE_UPDATE, 5'd10, 32'h0002_0000, 1'b1);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Reconfigure while idle; phases 1 and 2 sweep extremes of every register, later ones random
      case (ph)
        0: ;
        1: begin
          cfg_write(CFG_LR, 32'hFFFF_FFFF);
          cfg_write(CFG_B1, 32'd0);
          cfg_write(CFG_B2, 32'd0);
          cfg_write(CFG_EPS, 32'd0);
          // Zero denominator: fresh load, zero gradient, zero epsilon
          push_item(MODE_LOAD, 5'd3, 32'h0000_1000, 1'b0);
          push_item(MODE_UPDATE, 5'd3, 32'h0000_0000, 1'b1);
          push_item(MODE_LOAD, 5'd4, 32'h7FFF_0000, 1'b0);
          push_item(MODE_UPDATE, 5'd4, 32'h8000_0000, 1'b0);
        end
        2: begin
          cfg_write(CFG_LR, 32'd0);
          cfg_write(CFG_B1, 32'hFFFF);
          cfg_write(CFG_B2, 32'hFFFF);
          cfg_write(CFG_EPS, 32'hFFFF_FFFF);
        end
        default: begin
          cfg_write(CFG_LR, $urandom());
          cfg_write(CFG_B1, $urandom_range(32'hFFFF));
          cfg_write(CFG_B2, $urandom_range(32'hFFFF));
          cfg_write(CFG_EPS, $urandom_range(1) ? $urandom_range(1000) : $urandom());
        end
      endcase
      sender_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 16 : 0;
      push_random(RAND_PER_PHASE / 2);
      wait_drained();
      // Second half: bursts and gaps mixed in phase 2, back-to-back sending otherwise
      sender_idle_pct = (ph == 2) ? 70 : 0;
      push_random(RAND_PER_PHASE - RAND_PER_PHASE / 2);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
